@@ design/lws_pkg.sv @@
// Shared constants, types and the keyword table of the lexer with symbol table.
// No dependencies; only the lexer top level imports it.
package lws_pkg;

   localparam int SYMBOLS_DEF    = 128;
   localparam int ID_CHARS_DEF   = 19;
   localparam int NUM_DIGITS_DEF = 9;

   localparam int KW_COUNT = 24;
   localparam int KW_MAX   = 8;
   localparam int LEN_W    = 5;

   localparam logic [3:0] KIND_KEYWORD = 4'd0;
   localparam logic [3:0] KIND_IDENT   = 4'd1;
   localparam logic [3:0] KIND_NUMBER  = 4'd2;
   localparam logic [3:0] KIND_RELOP   = 4'd3;
   localparam logic [3:0] KIND_OTHER   = 4'd4;
   localparam logic [3:0] KIND_INVALID = 4'd5;
   localparam logic [3:0] KIND_FULL    = 4'd6;
   localparam logic [3:0] KIND_END     = 4'd7;
   localparam logic [3:0] KIND_END_CMT = 4'd8;

   localparam logic [2:0] REL_EQ = 3'd4;
   localparam logic [2:0] REL_NE = 3'd5;

   localparam logic [1:0] OP_LT  = 2'd0;
   localparam logic [1:0] OP_GT  = 2'd1;
   localparam logic [1:0] OP_EQ  = 2'd2;
   localparam logic [1:0] OP_NOT = 2'd3;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;

   // text is right justified: char j of a keyword of length L sits at bits (L-1-j)*8
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("int"), 64'("while"), 64'("break"), 64'("for"), 64'("do"), 64'("if"),
      64'("float"), 64'("char"), 64'("switch"), 64'("double"), 64'("short"),
      64'("long"), 64'("unsigned"), 64'("sizeof"), 64'("else"), 64'("register"),
      64'("extern"), 64'("static"), 64'("auto"), 64'("case"), 64'("break"),
      64'("volatile"), 64'("enum"), 64'("typedef")};
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd5, 4'd5, 4'd3, 4'd2, 4'd2, 4'd5, 4'd4, 4'd6, 4'd6, 4'd5, 4'd4,
      4'd8, 4'd6, 4'd4, 4'd8, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd8, 4'd4, 4'd7};

   typedef enum logic [2:0] {
      L_IDLE, L_NAME, L_NUM, L_LTGT, L_EQNOT, L_SLASH, L_CMT, L_CMT_STAR
   } lex_state_type;

   typedef enum logic [2:0] {
      E_IDLE, E_PROC, E_KW, E_RD, E_CMP, E_INS, E_END
   } eng_state_type;

endpackage

@@ design/lws_if.sv @@
// Channel interfaces of the lexer: character beats in, token beats out.
// Plain valid/ready handshake; no package dependency.
interface lws_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_input;

   modport source (output valid, ch, end_of_input, input ready);
   modport sink   (input valid, ch, end_of_input, output ready);
endinterface

interface lws_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [4:0]  keyword_index;
   logic [6:0]  symbol_index;
   logic        is_new;
   logic [29:0] number_value;
   logic [2:0]  relop_code;
   logic [7:0]  other_char;
   logic        overflow;
   logic        last;

   modport source (output valid, kind, keyword_index, symbol_index, is_new, number_value,
                   relop_code, other_char, overflow, last, input ready);
   modport sink   (input valid, kind, keyword_index, symbol_index, is_new, number_value,
                   relop_code, other_char, overflow, last, output ready);
endinterface

@@ design/lws_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ design/lexer_with_symbol_table.sv @@
// Lexer top level: character state machine, keyword check and symbol table scan.
// Depends on lws_pkg, lws_if (channels) and lws_ram (symbol table rows).

// Each character beat is accepted in E_IDLE and handled in E_PROC; when a
// pending token is closed, E_PROC looks at the character again. At the end
// of a name the keyword check runs in E_KW and a keyword closes the name
// there. Otherwise the symbol table is scanned through its single read port,
// one stored symbol at a time through E_RD and E_CMP: a hit closes the name
// with the slot of the hit, a miss closes it with the insert or the
// table-full token once all stored symbols are compared. A stalled token
// output holds the engine in its state. Each table row holds the name, cut
// to ID_CHARS characters, and its length. The table comes up empty after
// reset with no clearing pass. An end beat flushes the pending token and then
// gives the end token. Up to two token beats follow one input beat; the last
// carries last = 1.
module lexer_with_symbol_table
   import lws_pkg::*;
#(
   parameter int SYMBOLS    = SYMBOLS_DEF,
   parameter int ID_CHARS   = ID_CHARS_DEF,
   parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
   input logic        clock,
   input logic        reset,
   lws_req_if.sink    req_chan,
   lws_rsp_if.source  rsp_chan
);

   localparam int CW    = $clog2(SYMBOLS + 1);
   localparam int AW    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int IW    = $clog2(ID_CHARS);
   localparam int ROW_W = LEN_W + ID_CHARS * 8;
   localparam logic [29:0] NUM_MAX = 30'(10 ** NUM_DIGITS - 1);

   eng_state_type eng_ff, eng_in;
   lex_state_type lex_ff, lex_in;
   logic [7:0]               ch_ff, ch_in;
   logic                     eoi_ff, eoi_in;
   logic                     cmt_end_ff, cmt_end_in;
   logic [ID_CHARS-1:0][7:0] ident_ff, ident_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic                     trunc_ff, trunc_in;
   logic [29:0]              acc_ff, acc_in;
   logic [3:0]               dc_ff, dc_in;
   logic [1:0]               op_ff, op_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;

   logic        ov_ff, ov_in;
   logic [3:0]  o_kind_ff, o_kind_in;
   logic [4:0]  o_kw_ff, o_kw_in;
   logic [6:0]  o_sym_ff, o_sym_in;
   logic        o_new_ff, o_new_in;
   logic [29:0] o_num_ff, o_num_in;
   logic [2:0]  o_rel_ff, o_rel_in;
   logic [7:0]  o_oc_ff, o_oc_in;
   logic        o_ovf_ff, o_ovf_in;
   logic        o_last_ff, o_last_in;

   logic             emit, out_free, ram_we;
   logic [ROW_W-1:0] rdata;
   logic             kw_hit, row_match;
   logic [4:0]       kw_idx;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // true when a character seen from idle gives an other-char token
   function automatic logic idle_emits(input logic [7:0] c);
      return !(is_letter(c) || is_digit(c) || c == CH_LT || c == CH_GT || c == CH_EQ ||
               c == CH_BANG || c == CH_SLASH || c == CH_SPACE || c == CH_TAB || c == CH_NL);
   endfunction

   lws_ram #(.WIDTH(ROW_W), .DEPTH(SYMBOLS)) u_symtab (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata ({len_ff, ident_ff}),
      .raddr (idx_ff[AW-1:0]),
      .rdata (rdata)
   );

   // keyword compare against the constant table, first hit wins
   always_comb begin
      logic hit;
      kw_hit = 1'b0;
      kw_idx = '0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         hit = (len_ff == LEN_W'(KW_LEN[k]));
         for (int j = 0; j < KW_MAX; j++) begin
            if (j < int'(KW_LEN[k]) &&
                ident_ff[j] != KW_TEXT[k][(int'(KW_LEN[k]) - 1 - j) * 8 +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            kw_hit = 1'b1;
            kw_idx = 5'(k);
         end
      end
   end

   always_comb begin
      row_match = (rdata[ROW_W-1 -: LEN_W] == len_ff);
      for (int j = 0; j < ID_CHARS; j++) begin
         if (LEN_W'(j) < len_ff && rdata[j*8 +: 8] != ident_ff[j]) begin
            row_match = 1'b0;
         end
      end
   end

   assign out_free = !ov_ff || rsp_chan.ready;

   always_comb begin
      logic name_done;
      eng_in     = eng_ff;
      lex_in     = lex_ff;
      ch_in      = ch_ff;
      eoi_in     = eoi_ff;
      cmt_end_in = cmt_end_ff;
      ident_in   = ident_ff;
      len_in     = len_ff;
      trunc_in   = trunc_ff;
      acc_in     = acc_ff;
      dc_in      = dc_ff;
      op_in      = op_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      ram_we     = 1'b0;
      name_done  = 1'b0;
      emit       = 1'b0;
      o_kind_in  = KIND_OTHER;
      o_kw_in    = '0;
      o_sym_in   = '0;
      o_new_in   = 1'b0;
      o_num_in   = '0;
      o_rel_in   = '0;
      o_oc_in    = '0;
      o_ovf_in   = 1'b0;
      o_last_in  = 1'b1;

      unique case (eng_ff)
         E_IDLE: begin
            if (req_chan.valid) begin
               ch_in  = req_chan.ch;
               eoi_in = req_chan.end_of_input;
               eng_in = E_PROC;
            end
         end
         E_PROC: begin
            eng_in = E_IDLE;
            if (eoi_ff) begin
               cmt_end_in = (lex_ff == L_CMT) || (lex_ff == L_CMT_STAR);
               eng_in     = E_END;
               o_last_in  = 1'b0;
               unique case (lex_ff)
                  L_NAME:  eng_in = E_KW;
                  L_NUM: begin
                     emit      = 1'b1;
                     o_kind_in = KIND_NUMBER;
                     o_num_in  = acc_ff;
                     o_ovf_in  = dc_ff > 4'(NUM_DIGITS);
                  end
                  L_LTGT: begin
                     emit      = 1'b1;
                     o_kind_in = KIND_RELOP;
                     o_rel_in  = {op_ff, 1'b0};
                  end
                  L_EQNOT: begin
                     emit      = 1'b1;
                     o_oc_in   = (op_ff == OP_NOT) ? CH_BANG : CH_EQ;
                  end
                  L_SLASH: begin
                     emit      = 1'b1;
                     o_kind_in = KIND_INVALID;
                  end
                  default: ;
               endcase
            end else begin
               unique case (lex_ff)
                  L_IDLE: begin
                     if (is_letter(ch_ff)) begin
                        lex_in      = L_NAME;
                        len_in      = LEN_W'(1);
                        trunc_in    = 1'b0;
                        ident_in[0] = ch_ff;
                     end else if (is_digit(ch_ff)) begin
                        lex_in = L_NUM;
                        acc_in = 30'(ch_ff[3:0]);
                        dc_in  = 4'd1;
                     end else if (ch_ff == CH_LT || ch_ff == CH_GT) begin
                        lex_in = L_LTGT;
                        op_in  = (ch_ff == CH_LT) ? OP_LT : OP_GT;
                     end else if (ch_ff == CH_EQ || ch_ff == CH_BANG) begin
                        lex_in = L_EQNOT;
                        op_in  = (ch_ff == CH_EQ) ? OP_EQ : OP_NOT;
                     end else if (ch_ff == CH_SLASH) begin
                        lex_in = L_SLASH;
                     end else if (idle_emits(ch_ff)) begin
                        emit    = 1'b1;
                        o_oc_in = ch_ff;
                     end
                  end
                  L_NAME: begin
                     if (is_letter(ch_ff) || is_digit(ch_ff)) begin
                        if (len_ff < LEN_W'(ID_CHARS)) begin
                           ident_in[len_ff[IW-1:0]] = ch_ff;
                           len_in = len_ff + LEN_W'(1);
                        end else begin
                           trunc_in = 1'b1;
                        end
                     end else begin
                        eng_in = E_KW;
                     end
                  end
                  L_NUM: begin
                     if (is_digit(ch_ff)) begin
                        if (dc_ff < 4'(NUM_DIGITS)) begin
                           acc_in = 30'({acc_ff, 3'b0} + {acc_ff, 1'b0}) + 30'(ch_ff[3:0]);
                           dc_in  = dc_ff + 4'd1;
                        end else begin
                           acc_in = NUM_MAX;
                           dc_in  = 4'(NUM_DIGITS + 1);
                        end
                     end else begin
                        emit      = 1'b1;
                        o_kind_in = KIND_NUMBER;
                        o_num_in  = acc_ff;
                        o_ovf_in  = dc_ff > 4'(NUM_DIGITS);
                        o_last_in = !idle_emits(ch_ff);
                        lex_in    = L_IDLE;
                        eng_in    = E_PROC;
                     end
                  end
                  L_LTGT: begin
                     emit      = 1'b1;
                     o_kind_in = KIND_RELOP;
                     lex_in    = L_IDLE;
                     if (ch_ff == CH_EQ) begin
                        o_rel_in = {op_ff, 1'b1};
                     end else begin
                        o_rel_in  = {op_ff, 1'b0};
                        o_last_in = !idle_emits(ch_ff);
                        eng_in    = E_PROC;
                     end
                  end
                  L_EQNOT: begin
                     emit   = 1'b1;
                     lex_in = L_IDLE;
                     if (ch_ff == CH_EQ) begin
                        o_kind_in = KIND_RELOP;
                        o_rel_in  = (op_ff == OP_NOT) ? REL_NE : REL_EQ;
                     end else begin
                        o_oc_in   = (op_ff == OP_NOT) ? CH_BANG : CH_EQ;
                        o_last_in = !idle_emits(ch_ff);
                        eng_in    = E_PROC;
                     end
                  end
                  L_SLASH: begin
                     if (ch_ff == CH_STAR) begin
                        lex_in = L_CMT;
                     end else begin
                        emit      = 1'b1;
                        o_kind_in = KIND_INVALID;
                        o_last_in = !idle_emits(ch_ff);
                        lex_in    = L_IDLE;
                        eng_in    = E_PROC;
                     end
                  end
                  L_CMT: begin
                     if (ch_ff == CH_STAR) begin
                        lex_in = L_CMT_STAR;
                     end
                  end
                  L_CMT_STAR: begin
                     if (ch_ff == CH_SLASH) begin
                        lex_in = L_IDLE;
                     end else if (ch_ff != CH_STAR) begin
                        lex_in = L_CMT;
                     end
                  end
               endcase
            end
         end
         E_KW: begin
            idx_in = '0;
            if (kw_hit && !trunc_ff) begin
               emit      = 1'b1;
               name_done = 1'b1;
               o_kind_in = KIND_KEYWORD;
               o_kw_in   = kw_idx;
            end else begin
               eng_in = E_RD;
            end
         end
         E_RD: begin
            eng_in = (idx_ff == count_ff) ? E_INS : E_CMP;
         end
         E_CMP: begin
            if (row_match) begin
               emit      = 1'b1;
               name_done = 1'b1;
               o_kind_in = KIND_IDENT;
               o_sym_in  = 7'(idx_ff);
               o_ovf_in  = trunc_ff;
            end else begin
               idx_in = idx_ff + CW'(1);
               eng_in = E_RD;
            end
         end
         E_INS: begin
            emit      = 1'b1;
            name_done = 1'b1;
            o_ovf_in  = trunc_ff;
            if (count_ff >= CW'(SYMBOLS)) begin
               o_kind_in = KIND_FULL;
            end else begin
               o_kind_in = KIND_IDENT;
               o_sym_in  = 7'(count_ff);
               o_new_in  = 1'b1;
               ram_we    = out_free;
               count_in  = count_ff + CW'(1);
            end
         end
         E_END: begin
            emit      = 1'b1;
            o_kind_in = cmt_end_ff ? KIND_END_CMT : KIND_END;
            lex_in    = L_IDLE;
            eng_in    = E_IDLE;
         end
         default: eng_in = E_IDLE;
      endcase

      // a finished name continues with the end token or a second look at the char
      if (name_done) begin
         lex_in = L_IDLE;
         if (eoi_ff) begin
            o_last_in = 1'b0;
            eng_in    = E_END;
         end else begin
            o_last_in = !idle_emits(ch_ff);
            eng_in    = E_PROC;
         end
      end

      // output register busy: hold everything and retry next cycle
      if (emit && !out_free) begin
         emit     = 1'b0;
         eng_in   = eng_ff;
         lex_in   = lex_ff;
         count_in = count_ff;
         idx_in   = idx_ff;
      end
   end

   always_comb begin
      ov_in = ov_ff && !rsp_chan.ready;
      if (emit) begin
         ov_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eng_ff   <= E_IDLE;
         lex_ff   <= L_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         eng_ff   <= eng_in;
         lex_ff   <= lex_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      eoi_ff     <= eoi_in;
      cmt_end_ff <= cmt_end_in;
      ident_ff   <= ident_in;
      len_ff     <= len_in;
      trunc_ff   <= trunc_in;
      acc_ff     <= acc_in;
      dc_ff      <= dc_in;
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      if (emit) begin
         o_kind_ff <= o_kind_in;
         o_kw_ff   <= o_kw_in;
         o_sym_ff  <= o_sym_in;
         o_new_ff  <= o_new_in;
         o_num_ff  <= o_num_in;
         o_rel_ff  <= o_rel_in;
         o_oc_ff   <= o_oc_in;
         o_ovf_ff  <= o_ovf_in;
         o_last_ff <= o_last_in;
      end
   end

   assign req_chan.ready         = (eng_ff == E_IDLE);
   assign rsp_chan.valid         = ov_ff;
   assign rsp_chan.kind          = o_kind_ff;
   assign rsp_chan.keyword_index = o_kw_ff;
   assign rsp_chan.symbol_index  = o_sym_ff;
   assign rsp_chan.is_new        = o_new_ff;
   assign rsp_chan.number_value  = o_num_ff;
   assign rsp_chan.relop_code    = o_rel_ff;
   assign rsp_chan.other_char    = o_oc_ff;
   assign rsp_chan.overflow      = o_ovf_ff;
   assign rsp_chan.last          = o_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SYMBOLS))
      else $error("symbol count beyond table size");

   a_accept_proc: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> eng_ff == E_PROC)
      else $error("accepted beat not processed");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("token written over a waiting beat");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not advance symbol count");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (eng_ff == E_CMP) |-> idx_ff < count_ff)
      else $error("table scan past last symbol");

endmodule
